### hw/rtl/hampe_pkg.sv
package hampe_pkg;

    localparam int unsigned ChanW   = 8;
    localparam int unsigned CodeW   = 8;
    localparam int unsigned ErrW    = 10;
    localparam int unsigned InDataW = 24;
    localparam int unsigned InUserW = 3;

    // configuration register indexes
    localparam logic CFG_HAM8_MODE     = 1'b0;
    localparam logic CFG_DITHER_ENABLE = 1'b1;

    // code prefixes
    localparam logic [7:0] HAM8_MOD_RED   = 8'h80;
    localparam logic [7:0] HAM8_MOD_GREEN = 8'hC0;
    localparam logic [7:0] HAM8_MOD_BLUE  = 8'h40;
    localparam logic [7:0] HAM6_MOD_RED   = 8'h20;
    localparam logic [7:0] HAM6_MOD_GREEN = 8'h30;
    localparam logic [7:0] HAM6_MOD_BLUE  = 8'h10;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } rgb_t;

    // everything about the "set" candidates that does not depend on held state
    typedef struct packed {
        logic [1:0]      q_red;
        logic [1:0]      q_green;
        logic [1:0]      q_blue;
        logic [ErrW-1:0] err8;
        logic [3:0]      grey_idx;
        logic [ErrW-1:0] err6;
    } set_cand_t;

    typedef struct packed {
        logic [CodeW-1:0] code;
        rgb_t             held;
    } decision_t;

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        absdiff8 = (a < b) ? (b - a) : (a - b);
    endfunction

    // round(v * 3 / 255)
    function automatic logic [1:0] cube_index(input logic [7:0] v);
        logic [1:0] q;
        q = 2'd0;
        if (v >= 8'd43)  q = 2'd1;
        if (v >= 8'd128) q = 2'd2;
        if (v >= 8'd213) q = 2'd3;
        cube_index = q;
    endfunction

    function automatic logic [7:0] cube_level(input logic [1:0] q);
        logic [7:0] lvl;
        case (q)
            2'd0:    lvl = 8'd0;
            2'd1:    lvl = 8'd85;
            2'd2:    lvl = 8'd170;
            default: lvl = 8'd255;
        endcase
        cube_level = lvl;
    endfunction

    // floor((15*a + 127) / 255) == floor((a + 8) / 17)
    function automatic logic [3:0] grey_index(input logic [7:0] a);
        logic [8:0] a8;
        logic [3:0] q;
        a8 = {1'b0, a} + 9'd8;
        q  = 4'd0;
        for (int k = 1; k < 16; k++) begin
            if (a8 >= 9'(17 * k)) q = q + 4'd1;
        end
        grey_index = q;
    endfunction

    function automatic logic [3:0] bayer4(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] t;
        case ({row, col})
            4'h0: t = 4'd0;   4'h1: t = 4'd8;   4'h2: t = 4'd2;   4'h3: t = 4'd10;
            4'h4: t = 4'd12;  4'h5: t = 4'd4;   4'h6: t = 4'd14;  4'h7: t = 4'd6;
            4'h8: t = 4'd3;   4'h9: t = 4'd11;  4'hA: t = 4'd1;   4'hB: t = 4'd9;
            4'hC: t = 4'd15;  4'hD: t = 4'd7;   4'hE: t = 4'd13;  default: t = 4'd5;
        endcase
        bayer4 = t;
    endfunction

    function automatic logic [7:0] sat_add8(input logic [7:0] v, input logic [3:0] t);
        logic [8:0] s;
        s = {1'b0, v} + {5'b0, t};
        sat_add8 = s[8] ? 8'hFF : s[7:0];
    endfunction

endpackage

### hw/rtl/hampe_set_quant.sv
module hampe_set_quant
    import hampe_pkg::*;
(
    input  rgb_t      pix,
    output set_cand_t cand
);

    logic [1:0]  qr, qg, qb;
    logic [9:0]  sum;
    logic [19:0] prod;
    logic [7:0]  avg;
    logic [3:0]  qi;
    logic [7:0]  gv;

    assign qr = cube_index(pix.red);
    assign qg = cube_index(pix.green);
    assign qb = cube_index(pix.blue);

    // sum / 3 through reciprocal, exact for sums below 2048
    assign sum  = {2'b0, pix.red} + {2'b0, pix.green} + {2'b0, pix.blue};
    assign prod = {10'b0, sum} * 20'd683;
    assign avg  = prod[18:11];
    assign qi   = grey_index(avg);
    assign gv   = {qi, qi};

    assign cand.q_red    = qr;
    assign cand.q_green  = qg;
    assign cand.q_blue   = qb;
    assign cand.err8     = {2'b0, absdiff8(pix.red, cube_level(qr))}
                         + {2'b0, absdiff8(pix.green, cube_level(qg))}
                         + {2'b0, absdiff8(pix.blue, cube_level(qb))};
    assign cand.grey_idx = qi;
    assign cand.err6     = {2'b0, absdiff8(pix.red, gv)}
                         + {2'b0, absdiff8(pix.green, gv)}
                         + {2'b0, absdiff8(pix.blue, gv)};

endmodule

### hw/rtl/hampe_decide.sv
module hampe_decide
    import hampe_pkg::*;
(
    input  logic      ham8_mode,
    input  logic [3:0] thresh,
    input  rgb_t      pix,
    input  set_cand_t cand,
    input  rgb_t      held,
    output decision_t dec
);

    logic [7:0] dr, dg, db;
    logic [9:0] er, eg, eb;
    logic [3:0] t;
    logic [7:0] vr, vg, vb;
    logic [9:0] held_sum;
    logic signed [9:0]  del_r, del_g, del_b, best;
    logic [1:0]         chan;
    logic signed [10:0] mod_cost;
    logic               set6;

    assign dr = absdiff8(pix.red, held.red);
    assign dg = absdiff8(pix.green, held.green);
    assign db = absdiff8(pix.blue, held.blue);

    assign er = {8'b0, pix.red[1:0]} + {2'b0, dg} + {2'b0, db};
    assign eg = {2'b0, dr} + {8'b0, pix.green[1:0]} + {2'b0, db};
    assign eb = {2'b0, dr} + {2'b0, dg} + {8'b0, pix.blue[1:0]};

    // HAM8 steps are 4 wide, so the dither entry is scaled down
    assign t  = ham8_mode ? {2'b0, thresh[3:2]} : thresh;
    assign vr = sat_add8(pix.red, t);
    assign vg = sat_add8(pix.green, t);
    assign vb = sat_add8(pix.blue, t);

    assign held_sum = {2'b0, dr} + {2'b0, dg} + {2'b0, db};
    assign del_r = signed'({6'b0, pix.red[3:0]})   - signed'({2'b0, dr});
    assign del_g = signed'({6'b0, pix.green[3:0]}) - signed'({2'b0, dg});
    assign del_b = signed'({6'b0, pix.blue[3:0]})  - signed'({2'b0, db});

    always_comb
    begin
        best = del_r;
        chan = 2'd0;
        if (del_g < best)
        begin
            best = del_g;
            chan = 2'd1;
        end
        if (del_b < best)
        begin
            best = del_b;
            chan = 2'd2;
        end
    end

    assign mod_cost = signed'({1'b0, held_sum}) + signed'({best[9], best});
    assign set6     = signed'({1'b0, cand.err6}) <= mod_cost;

    always_comb
    begin
        dec.held = held;
        dec.code = '0;
        if (ham8_mode)
        begin
            if (cand.err8 <= er && cand.err8 <= eg && cand.err8 <= eb)
            begin
                dec.held.red   = cube_level(cand.q_red);
                dec.held.green = cube_level(cand.q_green);
                dec.held.blue  = cube_level(cand.q_blue);
                dec.code       = {2'b00, cand.q_red, cand.q_green, cand.q_blue};
            end
            else if (er <= eg && er <= eb)
            begin
                dec.held.red = {vr[7:2], 2'b00};
                dec.code     = HAM8_MOD_RED | {2'b00, vr[7:2]};
            end
            else if (eg <= eb)
            begin
                dec.held.green = {vg[7:2], 2'b00};
                dec.code       = HAM8_MOD_GREEN | {2'b00, vg[7:2]};
            end
            else
            begin
                dec.held.blue = {vb[7:2], 2'b00};
                dec.code      = HAM8_MOD_BLUE | {2'b00, vb[7:2]};
            end
        end
        else if (set6)
        begin
            dec.held.red   = {cand.grey_idx, cand.grey_idx};
            dec.held.green = {cand.grey_idx, cand.grey_idx};
            dec.held.blue  = {cand.grey_idx, cand.grey_idx};
            dec.code       = {4'b0, cand.grey_idx};
        end
        else
        begin
            case (chan)
                2'd0:
                begin
                    dec.held.red = {vr[7:4], 4'b0};
                    dec.code     = HAM6_MOD_RED | {4'b0, vr[7:4]};
                end
                2'd1:
                begin
                    dec.held.green = {vg[7:4], 4'b0};
                    dec.code       = HAM6_MOD_GREEN | {4'b0, vg[7:4]};
                end
                default:
                begin
                    dec.held.blue = {vb[7:4], 4'b0};
                    dec.code      = HAM6_MOD_BLUE | {4'b0, vb[7:4]};
                end
            endcase
        end
    end

endmodule

### hw/rtl/ham_pixel_encoder.sv
// Hold-and-modify pixel encoder, HAM8 or HAM6.
// Input stream s_axis: one RGB pixel per word; tuser carries the line start
// flag and the row number modulo 4 for the dither pattern. Output stream
// m_axis: one code byte per pixel, in order.
// cfg port: write ham8_mode (index 0) or dither_enable (index 1) while the
// stream is idle; the value applies from the next pixel.
// Throughput: one pixel per clock while m_axis_tready is high. The held
// colour feeds back through a single compare/select stage, which sets the
// clock-to-clock path; the palette quantization is done ahead of the
// input register. A pixel goes from the input register into the output
// register, which sets m_axis_tvalid, once that register is free or read.
// Reset: held colour black, column phase 0, HAM8 mode, dither off, both
// stages empty.
// Stall: when m_axis_tready is low the output word holds and the input
// register still takes one word; further input then waits.
module ham_pixel_encoder
    import hampe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [InDataW-1:0] s_axis_tdata,   // red, green, blue
    input  logic [InUserW-1:0] s_axis_tuser,   // line_start, row_phase[1:0]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [CodeW-1:0]   m_axis_tdata,   // code
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic               cfg_wdata
);

    logic       ham8_mode_reg, dither_enable_reg;
    logic       in_valid_reg, in_valid_next;
    rgb_t       pix_reg;
    set_cand_t  cand_reg;
    logic       line_start_reg;
    logic [1:0] row_phase_reg;
    logic       out_valid_reg, out_valid_next;
    logic [CodeW-1:0] code_reg;
    rgb_t       held_reg;
    logic [1:0] col_reg;

    rgb_t       pix_in;
    set_cand_t  cand_in;
    logic       s_fire, advance;
    rgb_t       held_eff;
    logic [1:0] col_eff;
    logic [3:0] thresh;
    decision_t  dec;

    assign pix_in.red   = s_axis_tdata[7:0];
    assign pix_in.green = s_axis_tdata[15:8];
    assign pix_in.blue  = s_axis_tdata[23:16];

    hampe_set_quant u_set_quant (
        .pix  (pix_in),
        .cand (cand_in)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // line start clears held colour and phase before the pixel is coded
    assign held_eff = line_start_reg ? '0 : held_reg;
    assign col_eff  = line_start_reg ? 2'd0 : col_reg;
    assign thresh   = dither_enable_reg ? bayer4(row_phase_reg, col_eff) : 4'd0;

    hampe_decide u_decide (
        .ham8_mode (ham8_mode_reg),
        .thresh    (thresh),
        .pix       (pix_reg),
        .cand      (cand_reg),
        .held      (held_eff),
        .dec       (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ham8_mode_reg     <= 1'b1;
            dither_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HAM8_MODE:     ham8_mode_reg     <= cfg_wdata;
                CFG_DITHER_ENABLE: dither_enable_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            col_reg       <= 2'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                held_reg <= dec.held;
                col_reg  <= col_eff + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            pix_reg        <= pix_in;
            cand_reg       <= cand_in;
            line_start_reg <= s_axis_tuser[0];
            row_phase_reg  <= s_axis_tuser[2:1];
        end
        if (advance)
        begin
            code_reg <= dec.code;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = code_reg;

    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("output register not filled after stage advance");

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled while output register empty");

    a_line_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
        advance && line_start_reg |=> col_reg == 2'd1)
        else $error("column phase not restarted at line start");

    a_ham6_high_bits: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !ham8_mode_reg |=> code_reg[7:6] == 2'b00)
        else $error("HAM6 code has high bits set");

    a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(held_reg) && $stable(col_reg))
        else $error("held state changed without a pixel");

endmodule
